// ===== hdl/bsd_pkg.sv =====
// Shared types, constants and status codes for the BMP stream decoder.
package bsd_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
    localparam logic [31:0] HEADER_BYTES  = 32'd54;
    localparam logic [15:0] DEPTH_24      = 16'd24;
    localparam logic [15:0] DEPTH_32      = 16'd32;
    localparam logic [7:0]  OPAQUE_ALPHA  = 8'hFF;

    localparam logic [5:0] SIG_FIRST    = 6'd0;
    localparam logic [5:0] DATA_FIRST   = 6'd10;
    localparam logic [5:0] WIDTH_FIRST  = 6'd18;
    localparam logic [5:0] HEIGHT_FIRST = 6'd22;
    localparam logic [5:0] DEPTH_FIRST  = 6'd28;
    localparam logic [5:0] HEADER_LAST  = 6'd53;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_OK               = 4'd0,
        ST_SMALL            = 4'd1,
        ST_SIGNATURE        = 4'd2,
        ST_DIMS             = 4'd3,
        ST_OFFSET           = 4'd4,
        ST_DEPTH            = 4'd5,
        ST_TRUNCATED        = 4'd6,
        ST_TOO_LARGE        = 4'd7,
        ST_OFFSET_IN_HEADER = 4'd8
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic       is_status;
        logic [9:0] pixel_x;
        logic [9:0] pixel_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        status_t    status;
        logic       run_end;
    } out_t;

    typedef struct packed {
        logic [1:0] count;
        out_t       first;
        out_t       second;
    } push_t;

endpackage

// ===== hdl/bsd_core.sv =====
// Header parser, pixel assembler and status logic of the BMP stream decoder.
module bsd_core
    import bsd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cfg_write_en,
    input  logic  cfg_write_data,
    input  logic  step,
    input  in_t   item,
    output push_t push
);

    localparam int COL_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
    localparam int RBC_W = $clog2(4 * MAX_WIDTH + 4);

    function automatic logic [31:0] gather(input logic [31:0] acc, input logic [1:0] k,
                                           input logic [7:0] b, input logic little);
        logic [31:0] r;
        if (little)
        begin
            r = acc | ({24'd0, b} << {k, 3'b000});
        end
        else
        begin
            r = {acc[23:0], b};
        end
        return r;
    endfunction

    logic             order_reg;
    logic [31:0]      byte_position_reg, byte_position_next;
    logic [15:0]      signature_reg, signature_next;
    logic [31:0]      data_start_reg, data_start_next;
    logic [31:0]      width_reg, width_next;
    logic [31:0]      height_reg, height_next;
    logic [15:0]      depth_reg, depth_next;
    logic [COL_W-1:0] column_reg, column_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [RBC_W-1:0] row_byte_reg, row_byte_next;
    logic [1:0]       pixel_byte_reg, pixel_byte_next;
    logic [23:0]      held_reg, held_next;
    status_t          pending_reg, pending_next;
    logic             done_reg, done_next;

    logic [5:0]       hp;
    logic [31:0]      gathered;
    logic             bpp4;
    logic [RBC_W-1:0] wx;
    logic [RBC_W-1:0] used;
    logic [RBC_W-1:0] used_p3;
    logic [RBC_W-1:0] stride;
    logic [RBC_W-1:0] row_byte_inc;
    logic             emit;
    status_t          code;
    logic [31:0]      col_ext;
    logic [31:0]      y_ext;
    out_t             pixel_res;
    out_t             status_res;

    assign hp      = byte_position_reg[5:0];
    assign bpp4    = (depth_reg == DEPTH_32);
    assign wx      = RBC_W'(width_reg[COL_W-1:0]);
    assign used    = bpp4 ? (wx << 2) : ((wx << 1) + wx);
    assign used_p3 = used + RBC_W'(3);
    assign stride  = bpp4 ? used : {used_p3[RBC_W-1:2], 2'b00};
    assign col_ext = 32'(column_reg);
    assign y_ext   = height_reg - 32'd1 - 32'(row_reg);

    always_comb
    begin
        pixel_res           = '0;
        pixel_res.is_status = 1'b0;
        pixel_res.pixel_x   = col_ext[9:0];
        pixel_res.pixel_y   = y_ext[9:0];
        pixel_res.red       = bpp4 ? held_reg[23:16] : item.data_byte;
        pixel_res.green     = held_reg[15:8];
        pixel_res.blue      = held_reg[7:0];
        pixel_res.alpha     = bpp4 ? item.data_byte : OPAQUE_ALPHA;
        pixel_res.status    = ST_OK;
        pixel_res.run_end   = !item.last_byte;
    end

    always_comb
    begin
        byte_position_next = byte_position_reg;
        signature_next     = signature_reg;
        data_start_next    = data_start_reg;
        width_next         = width_reg;
        height_next        = height_reg;
        depth_next         = depth_reg;
        column_next        = column_reg;
        row_next           = row_reg;
        row_byte_next      = row_byte_reg;
        pixel_byte_next    = pixel_byte_reg;
        held_next          = held_reg;
        pending_next       = pending_reg;
        done_next          = done_reg;
        gathered           = '0;
        emit               = 1'b0;
        code               = ST_OK;
        row_byte_inc       = row_byte_reg + RBC_W'(1);

        if (byte_position_reg < HEADER_BYTES)
        begin
            if (hp <= SIG_FIRST + 6'd1)
            begin
                gathered = gather({16'd0, signature_reg}, 2'(hp - SIG_FIRST),
                                  item.data_byte, order_reg);
                signature_next = gathered[15:0];
            end
            else if (hp >= DATA_FIRST && hp <= DATA_FIRST + 6'd3)
            begin
                gathered = gather(data_start_reg, 2'(hp - DATA_FIRST),
                                  item.data_byte, order_reg);
                data_start_next = gathered;
            end
            else if (hp >= WIDTH_FIRST && hp <= WIDTH_FIRST + 6'd3)
            begin
                gathered = gather(width_reg, 2'(hp - WIDTH_FIRST), item.data_byte, order_reg);
                width_next = gathered;
            end
            else if (hp >= HEIGHT_FIRST && hp <= HEIGHT_FIRST + 6'd3)
            begin
                gathered = gather(height_reg, 2'(hp - HEIGHT_FIRST), item.data_byte, order_reg);
                height_next = gathered;
            end
            else if (hp >= DEPTH_FIRST && hp <= DEPTH_FIRST + 6'd1)
            begin
                gathered = gather({16'd0, depth_reg}, 2'(hp - DEPTH_FIRST),
                                  item.data_byte, order_reg);
                depth_next = gathered[15:0];
            end

            if (hp == HEADER_LAST)
            begin
                if (signature_reg != BMP_SIGNATURE)
                begin
                    pending_next = ST_SIGNATURE;
                end
                else if (width_reg == 32'd0 || width_reg[31] ||
                         height_reg == 32'd0 || height_reg[31])
                begin
                    pending_next = ST_DIMS;
                end
                else if (width_reg > 32'(MAX_WIDTH) || height_reg > 32'(MAX_HEIGHT))
                begin
                    pending_next = ST_TOO_LARGE;
                end
                else if (depth_reg != DEPTH_24 && depth_reg != DEPTH_32)
                begin
                    pending_next = ST_DEPTH;
                end
                else if (data_start_reg < HEADER_BYTES)
                begin
                    pending_next = ST_OFFSET_IN_HEADER;
                end
                else
                begin
                    pending_next = ST_OK;
                end
            end
        end
        else if (pending_reg == ST_OK && !done_reg && byte_position_reg >= data_start_reg)
        begin
            if (row_byte_reg < used)
            begin
                if (pixel_byte_reg == (bpp4 ? 2'd3 : 2'd2))
                begin
                    emit = 1'b1;
                    if (col_ext + 32'd1 == width_reg && 32'(row_reg) + 32'd1 == height_reg)
                    begin
                        done_next = 1'b1;
                    end
                    column_next     = column_reg + COL_W'(1);
                    held_next       = '0;
                    pixel_byte_next = '0;
                end
                else
                begin
                    held_next       = held_reg | (24'(item.data_byte) << {pixel_byte_reg, 3'b000});
                    pixel_byte_next = pixel_byte_reg + 2'd1;
                end
            end
            if (row_byte_inc >= stride)
            begin
                row_byte_next = '0;
                column_next   = '0;
                row_next      = row_reg + ROW_W'(1);
            end
            else
            begin
                row_byte_next = row_byte_inc;
            end
        end

        if (!(&byte_position_reg))
        begin
            byte_position_next = byte_position_reg + 32'd1;
        end

        if (item.last_byte)
        begin
            if (byte_position_reg < HEADER_BYTES - 32'd1)
            begin
                code = ST_SMALL;
            end
            else if (pending_next == ST_SIGNATURE || pending_next == ST_DIMS ||
                     pending_next == ST_TOO_LARGE)
            begin
                code = pending_next;
            end
            else if (data_start_next > byte_position_reg)
            begin
                code = ST_OFFSET;
            end
            else if (pending_next != ST_OK)
            begin
                code = pending_next;
            end
            else if (!done_next)
            begin
                code = ST_TRUNCATED;
            end
            else
            begin
                code = ST_OK;
            end

            byte_position_next = '0;
            signature_next     = '0;
            data_start_next    = '0;
            width_next         = '0;
            height_next        = '0;
            depth_next         = '0;
            column_next        = '0;
            row_next           = '0;
            row_byte_next      = '0;
            pixel_byte_next    = '0;
            held_next          = '0;
            pending_next       = ST_OK;
            done_next          = 1'b0;
        end
    end

    always_comb
    begin
        status_res           = '0;
        status_res.is_status = 1'b1;
        status_res.status    = code;
        status_res.run_end   = 1'b1;
    end

    always_comb
    begin
        push.count  = step ? ({1'b0, emit} + {1'b0, item.last_byte}) : 2'd0;
        push.first  = emit ? pixel_res : status_res;
        push.second = status_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= 1'b1;
        end
        else if (cfg_write_en)
        begin
            order_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            signature_reg     <= '0;
            data_start_reg    <= '0;
            width_reg         <= '0;
            height_reg        <= '0;
            depth_reg         <= '0;
            column_reg        <= '0;
            row_reg           <= '0;
            row_byte_reg      <= '0;
            pixel_byte_reg    <= '0;
            held_reg          <= '0;
            pending_reg       <= ST_OK;
            done_reg          <= 1'b0;
        end
        else if (step)
        begin
            byte_position_reg <= byte_position_next;
            signature_reg     <= signature_next;
            data_start_reg    <= data_start_next;
            width_reg         <= width_next;
            height_reg        <= height_next;
            depth_reg         <= depth_next;
            column_reg        <= column_next;
            row_reg           <= row_next;
            row_byte_reg      <= row_byte_next;
            pixel_byte_reg    <= pixel_byte_next;
            held_reg          <= held_next;
            pending_reg       <= pending_next;
            done_reg          <= done_next;
        end
    end

endmodule

// ===== hdl/bsd_out_queue.sv =====
// Result queue that takes up to two results per cycle and hands out one while the output is not stalled.
module bsd_out_queue
    import bsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  push_t              push,
    output logic               out_valid,
    input  logic               out_stall,
    output out_t               out_data,
    output logic [LEVEL_W-1:0] level
);

    out_t               mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [PTR_W-1:0]   wr_ptr_plus1;
    logic               pop;

    assign out_valid    = (level_reg != '0);
    assign out_data     = mem[rd_ptr_reg];
    assign level        = level_reg;
    assign pop          = out_valid && !out_stall;
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_next  = wr_ptr_reg + PTR_W'(push.count);
    assign rd_ptr_next  = rd_ptr_reg + PTR_W'(pop);
    assign level_next   = level_reg + LEVEL_W'(push.count) - LEVEL_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

// ===== hdl/bmp_stream_decoder_top.sv =====
// Top level of the BMP stream decoder: input register, decoder core and result queue.
// A byte is held in the input register, decoded once the result queue has room, and its
// results are written to the result queue, which offers them. Throughput is one byte per cycle
// while the queue has room; a pixel and the status from one byte fill two of its four entries.
// Asynchronous reset clears all stream state at once and sets the byte order to little-endian.
module bmp_stream_decoder_top
    import bsd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_write_en,
    input  logic cfg_write_data,
    input  logic in_valid,
    output logic in_stall,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_stall,
    output out_t out_data
);

    logic               in_valid_reg;
    in_t                in_data_reg;
    logic               step;
    push_t              push;
    logic [LEVEL_W-1:0] level;

    assign step     = in_valid_reg && (level <= LEVEL_W'(QUEUE_DEPTH - 2));
    assign in_stall = in_valid_reg && !step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_data_reg <= in_data;
        end
    end

    bsd_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .step           (step),
        .item           (in_data_reg),
        .push           (push)
    );

    bsd_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .level     (level)
    );

`ifndef SYNTHESIS
    a_push_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> step)
        else $error("Results pushed without a transaction being decoded.");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> (!push.first.is_status && !push.first.run_end &&
                                push.second.is_status && push.second.run_end))
        else $error("A result pair must be a pixel followed by the closing status.");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        level <= LEVEL_W'(QUEUE_DEPTH))
        else $error("Result queue has overflowed.");

    a_single_status: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd1 && push.first.is_status |-> push.first.run_end)
        else $error("A status result must close the transaction's results.");
`endif

endmodule
